FILE: design/atrd_pkg.sv
package atrd_pkg;

  typedef enum logic [1:0] {
    K_START,
    K_BYTE,
    K_TICK,
    K_NOP
  } kind_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
  } cmd_t;

  localparam logic [1:0] OPC_START = 2'd0;
  localparam logic [1:0] OPC_BYTE  = 2'd1;
  localparam logic [1:0] OPC_TICK  = 2'd2;

  localparam logic [2:0] ST_IDLE    = 3'd0;
  localparam logic [2:0] ST_WAIT    = 3'd1;
  localparam logic [2:0] ST_OK      = 3'd2;
  localparam logic [2:0] ST_ERR     = 3'd3;
  localparam logic [2:0] ST_TIMEOUT = 3'd4;

  localparam int WIN_LEN    = 9;
  localparam int PAT_OK_LEN = 6;
  localparam int KEPT_MAX   = 511;
  localparam int QDEPTH     = 2;

  localparam logic [7:0] PAT_OK [PAT_OK_LEN] = '{8'h0D, 8'h0A, 8'h4F, 8'h4B, 8'h0D, 8'h0A};
  localparam logic [7:0] PAT_ERR [WIN_LEN] =
    '{8'h0D, 8'h0A, 8'h45, 8'h52, 8'h52, 8'h4F, 8'h52, 8'h0D, 8'h0A};

  localparam logic [31:0] TIMEOUT_RST = 32'd1000;

endpackage

FILE: design/atrd_front.sv
module atrd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [7:0]          in_tdata,
  input  logic [1:0]          in_tuser,
  output logic                push,
  output atrd_pkg::cmd_t      push_cmd,
  input  logic                q_full
);

  logic           slot_vld_r, slot_vld_nxt;
  atrd_pkg::cmd_t slot_r, slot_nxt;
  atrd_pkg::cmd_t dec;

  always_comb begin
    dec.data = in_tdata;
    case (in_tuser)
      atrd_pkg::OPC_START: dec.kind = atrd_pkg::K_START;
      atrd_pkg::OPC_BYTE:  dec.kind = atrd_pkg::K_BYTE;
      atrd_pkg::OPC_TICK:  dec.kind = atrd_pkg::K_TICK;
      default:             dec.kind = atrd_pkg::K_NOP;
    endcase
  end

  assign push      = slot_vld_r & ~q_full;
  assign in_tready = ~slot_vld_r | ~q_full;
  assign push_cmd  = slot_r;

  always_comb begin
    slot_vld_nxt = slot_vld_r;
    slot_nxt     = slot_r;
    if (push) begin
      slot_vld_nxt = 1'b0;
    end
    if (in_tvalid && in_tready) begin
      slot_vld_nxt = 1'b1;
      slot_nxt     = dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_vld_r <= 1'b0;
    end else begin
      slot_vld_r <= slot_vld_nxt;
    end
    slot_r <= slot_nxt;
  end

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (slot_vld_r && q_full) |=> (slot_vld_r && slot_r == $past(slot_r)))
    else $error("front slot lost while queue full");

endmodule

FILE: design/atrd_fifo.sv
module atrd_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  atrd_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output atrd_pkg::cmd_t head
);

  localparam int PW = $clog2(atrd_pkg::QDEPTH);

  atrd_pkg::cmd_t mem [atrd_pkg::QDEPTH];
  logic [PW-1:0]  wp_r, rp_r;
  logic [PW:0]    cnt_r;

  assign full  = (cnt_r == (PW+1)'(atrd_pkg::QDEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= wp_r + 1'b1;
      end
      if (pop) begin
        rp_r <= rp_r + 1'b1;
      end
      cnt_r <= cnt_r + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= (PW+1)'(atrd_pkg::QDEPTH))
    else $error("queue count out of range");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == '0 || cnt_r == (PW+1)'(atrd_pkg::QDEPTH)) |-> wp_r == rp_r)
    else $error("queue pointers inconsistent with count");

endmodule

FILE: design/atrd_back.sv
module atrd_back #(
  parameter int RESP_CAPACITY = 512
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           cfg_we,
  input  logic [31:0]    cfg_data,
  input  logic           empty,
  input  atrd_pkg::cmd_t head,
  output logic           pop,
  output logic           out_tvalid,
  input  logic           out_tready,
  output logic [15:0]    out_tdata
);

  localparam int CNT_W = $clog2(RESP_CAPACITY);

  logic [31:0]      tmo_r;
  logic [2:0]       status_r, status_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]      ticks_r, ticks_nxt;
  logic [7:0]       win_r [atrd_pkg::WIN_LEN];
  logic [7:0]       win_nxt [atrd_pkg::WIN_LEN];
  logic [7:0]       shw [atrd_pkg::WIN_LEN];
  logic             kept_nxt;
  logic             ok_hit, err_hit;
  logic             ovld_r;
  logic [2:0]       ost_r;
  logic [8:0]       ocnt_r, ocnt_nxt;
  logic             okept_r;

  assign pop = ~empty & (~ovld_r | out_tready);

  always_comb begin
    for (int i = 0; i < atrd_pkg::WIN_LEN - 1; i++) begin
      shw[i] = win_r[i+1];
    end
    shw[atrd_pkg::WIN_LEN-1] = head.data;
    ok_hit = 1'b1;
    for (int i = 0; i < atrd_pkg::PAT_OK_LEN; i++) begin
      if (shw[atrd_pkg::WIN_LEN-atrd_pkg::PAT_OK_LEN+i] != atrd_pkg::PAT_OK[i]) begin
        ok_hit = 1'b0;
      end
    end
    err_hit = 1'b1;
    for (int i = 0; i < atrd_pkg::WIN_LEN; i++) begin
      if (shw[i] != atrd_pkg::PAT_ERR[i]) begin
        err_hit = 1'b0;
      end
    end
  end

  always_comb begin
    status_nxt = status_r;
    cnt_nxt    = cnt_r;
    ticks_nxt  = ticks_r;
    win_nxt    = win_r;
    kept_nxt   = 1'b0;
    case (head.kind)
      atrd_pkg::K_START: begin
        for (int i = 0; i < atrd_pkg::WIN_LEN; i++) begin
          win_nxt[i] = '0;
        end
        cnt_nxt    = '0;
        ticks_nxt  = '0;
        status_nxt = atrd_pkg::ST_WAIT;
      end
      atrd_pkg::K_BYTE: begin
        if (status_r == atrd_pkg::ST_WAIT) begin
          if (cnt_r < CNT_W'(RESP_CAPACITY - 1)) begin
            cnt_nxt  = cnt_r + 1'b1;
            kept_nxt = 1'b1;
            win_nxt  = shw;
            if (ok_hit) begin
              status_nxt = atrd_pkg::ST_OK;
            end else if (err_hit) begin
              status_nxt = atrd_pkg::ST_ERR;
            end
          end
          if (ticks_r >= tmo_r) begin
            status_nxt = atrd_pkg::ST_TIMEOUT;
          end
        end
      end
      atrd_pkg::K_TICK: begin
        if (status_r == atrd_pkg::ST_WAIT) begin
          if (ticks_r != '1) begin
            ticks_nxt = ticks_r + 32'd1;
          end
          if (ticks_nxt >= tmo_r) begin
            status_nxt = atrd_pkg::ST_TIMEOUT;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    if (CNT_W > 9 && cnt_nxt > CNT_W'(atrd_pkg::KEPT_MAX)) begin
      ocnt_nxt = 9'(atrd_pkg::KEPT_MAX);
    end else begin
      ocnt_nxt = 9'(cnt_nxt);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmo_r    <= atrd_pkg::TIMEOUT_RST;
      status_r <= atrd_pkg::ST_IDLE;
      cnt_r    <= '0;
      ticks_r  <= '0;
      ovld_r   <= 1'b0;
      for (int i = 0; i < atrd_pkg::WIN_LEN; i++) begin
        win_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        tmo_r <= cfg_data;
      end
      if (pop) begin
        status_r <= status_nxt;
        cnt_r    <= cnt_nxt;
        ticks_r  <= ticks_nxt;
        win_r    <= win_nxt;
        ovld_r   <= 1'b1;
      end else if (out_tready) begin
        ovld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ost_r   <= status_nxt;
      ocnt_r  <= ocnt_nxt;
      okept_r <= kept_nxt;
    end
  end

  assign out_tvalid = ovld_r;
  assign out_tdata  = {3'b000, okept_r, ocnt_r, ost_r};

  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r < CNT_W'(RESP_CAPACITY - 1) || cnt_r == CNT_W'(RESP_CAPACITY - 1))
    else $error("response count past capacity");

  a_idle_clear: assert property (@(posedge clk) disable iff (!rst_n)
    status_r == atrd_pkg::ST_IDLE |-> (cnt_r == '0 && ticks_r == '0))
    else $error("idle with nonzero counters");

  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head.kind == atrd_pkg::K_START) |=>
      (status_r == atrd_pkg::ST_WAIT && cnt_r == '0 && ticks_r == '0))
    else $error("start did not restart the wait");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    ##1 (cnt_r == '0 || cnt_r == $past(cnt_r) || cnt_r == $past(cnt_r) + 1'b1))
    else $error("response count jumped");

endmodule

FILE: design/at_response_terminator_detector.sv
// Channel | Dir | bits (low to high)
// in_     | in  | tuser: opcode[1:0]; tdata: data_byte[7:0]
// out_    | out | tdata: status[2:0], kept_count[11:3], byte_kept[12], zero[15:13]
// cfg_    | in  | cfg_data = timeout_ticks[31:0]
// One item per cycle sustained while out_tready stays high; a result passes the decode slot, queue, output register.
// Path: input decode slot, two-entry command queue, execute stage with output register.
// Reset (rst_n low, synchronous) clears status to idle, counters, window; timeout = 1000.
// Output stall backs up the queue, then the decode slot, then in_tready.
// cfg_ready is always high; write only while no beats are in flight.
module at_response_terminator_detector #(
  parameter int RESP_CAPACITY = 512
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // data_byte
  input  logic [1:0]  in_tuser,   // opcode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // status, kept_count, byte_kept
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data
);

  logic           push, pop, q_full, q_empty;
  atrd_pkg::cmd_t push_cmd, head;

  assign cfg_ready = 1'b1;

  atrd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .push      (push),
    .push_cmd  (push_cmd),
    .q_full    (q_full)
  );

  atrd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (head)
  );

  atrd_back #(
    .RESP_CAPACITY (RESP_CAPACITY)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_valid & cfg_ready),
    .cfg_data   (cfg_data),
    .empty      (q_empty),
    .head       (head),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: sim/at_response_terminator_detector_tb.sv
`timescale 1ns / 1ps

module at_response_terminator_detector_tb;

  localparam int RESP_CAP = 512;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_ITEMS = 1700;
  localparam logic [47:0] OK_TERM = 48'h0D0A_4F4B_0D0A;
  localparam logic [71:0] ERR_TERM = 72'h0D0A_4552_524F_520D_0A;

  class resp_scoreboard;
    typedef struct {
      logic [2:0] status;
      logic [8:0] kept;
      logic       byte_kept;
    } resp_t;

    logic [71:0] tail;
    logic [2:0]  state;
    int unsigned count;
    logic [31:0] ticks;
    logic [31:0] limit;
    resp_t       pending[$];
    int          errors;

    function new();
      limit = 32'd1000;
      tail = '0;
      state = atrd_pkg::ST_IDLE;
      count = 0;
      ticks = '0;
      errors = 0;
    endfunction

    function void set_limit(logic [31:0] v);
      limit = v;
    endfunction

    function void note_input(atrd_pkg::kind_t k, logic [7:0] d);
      resp_t r;
      r.byte_kept = 1'b0;
      case (k)
        atrd_pkg::K_START: begin
          tail = '0;
          count = 0;
          ticks = '0;
          state = atrd_pkg::ST_WAIT;
        end
        atrd_pkg::K_BYTE: if (state == atrd_pkg::ST_WAIT) begin
          if (count < RESP_CAP - 1) begin
            count++;
            r.byte_kept = 1'b1;
            tail = {tail[63:0], d};
            if (tail[47:0] == OK_TERM) state = atrd_pkg::ST_OK;
            else if (tail == ERR_TERM) state = atrd_pkg::ST_ERR;
          end
          if (ticks >= limit) state = atrd_pkg::ST_TIMEOUT;
        end
        atrd_pkg::K_TICK: if (state == atrd_pkg::ST_WAIT) begin
          if (ticks != '1) ticks++;
          if (ticks >= limit) state = atrd_pkg::ST_TIMEOUT;
        end
        default: ;
      endcase
      r.status = state;
      r.kept = (count > 511) ? 9'd511 : count[8:0];
      pending.push_back(r);
    endfunction

    task report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d, expected %0d", what, got, want);
      errors++;
    endtask

    task check_result(logic [15:0] t);
      resp_t r;
      if (pending.size() == 0) begin
        report_mismatch("result with none pending", t, 0);
      end else begin
        r = pending.pop_front();
        if (t[2:0] !== r.status) report_mismatch("status", t[2:0], r.status);
        if (t[11:3] !== r.kept) report_mismatch("kept_count", t[11:3], r.kept);
        if (t[12] !== r.byte_kept) report_mismatch("byte_kept", t[12], r.byte_kept);
      end
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // data_byte
  logic [1:0]  in_tuser = '0;   // opcode
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;       // status, kept_count, byte_kept
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data = '0;

  resp_scoreboard sb = new();
  bit gaps_on = 1'b1;
  int n_sent = 0;
  int cycle_count = 0;
  int stall_left = 0;

  at_response_terminator_detector #(.RESP_CAPACITY(RESP_CAP)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // result side: check accepted beats, random stall bursts
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (gaps_on && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task send(atrd_pkg::kind_t k, logic [7:0] d);
    if (gaps_on && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= d;
    in_tuser <= k;
    do @(posedge clk); while (!in_tready);
    sb.note_input(k, d);
    n_sent++;
  endtask

  // bytes go out most significant first
  task send_seq(logic [71:0] seq, int nbytes);
    for (int i = nbytes - 1; i >= 0; i--) send(atrd_pkg::K_BYTE, seq[i*8 +: 8]);
  endtask

  task send_filler(int n, bit with_ticks);
    for (int i = 0; i < n; i++) begin
      if (with_ticks && $urandom_range(0, 3) == 0) send(atrd_pkg::K_TICK, 8'($urandom));
      else send(atrd_pkg::K_BYTE, 8'($urandom));
    end
  endtask

  task drain();
    in_tvalid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_limit(logic [31:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_limit(v);
  endtask

  task random_response(logic [31:0] lim);
    logic [71:0] term;
    int nb;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        send(atrd_pkg::K_START, 8'($urandom));
        send_filler($urandom_range(0, 10), lim < 64);
        if ($urandom_range(0, 1)) send_seq(72'(OK_TERM), 6);
        else send_seq(ERR_TERM, 9);
        if ($urandom_range(0, 3) == 0) begin
          send(atrd_pkg::kind_t'($urandom_range(1, 3)), 8'($urandom));
        end
      end
      6: begin
        send(atrd_pkg::K_START, 8'($urandom));
        send_filler($urandom_range(0, 6), 1'b0);
        if ($urandom_range(0, 1)) begin
          nb = 6;
          term = 72'(OK_TERM) ^ (72'(1) << $urandom_range(0, 47));
        end else begin
          nb = 9;
          term = ERR_TERM ^ (72'(1) << $urandom_range(0, 71));
        end
        send_seq(term, nb);
        send_filler($urandom_range(0, 4), 1'b1);
      end
      7: begin
        send(atrd_pkg::K_START, 8'($urandom));
        repeat ($urandom_range(0, 8)) send(atrd_pkg::K_TICK, 8'($urandom));
        send_filler($urandom_range(0, 4), 1'b1);
      end
      default: begin
        repeat ($urandom_range(1, 8)) begin
          send(atrd_pkg::kind_t'($urandom_range(0, 3)), 8'($urandom));
        end
      end
    endcase
  endtask

  initial begin
    logic [31:0] lim;
    logic [7:0] b;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // idle items, unused opcode, ok / error matches, late items, restarts
    send(atrd_pkg::K_BYTE, 8'hFF);
    send(atrd_pkg::K_TICK, 8'h00);
    send(atrd_pkg::K_NOP, 8'hAA);
    send(atrd_pkg::K_START, 8'h00);
    send(atrd_pkg::K_BYTE, 8'h00);
    send(atrd_pkg::K_NOP, 8'h55);
    send_seq(72'(OK_TERM), 6);
    send(atrd_pkg::K_BYTE, 8'h0D);
    send(atrd_pkg::K_TICK, 8'hFF);
    send(atrd_pkg::K_START, 8'hFF);
    send_seq(ERR_TERM, 9);
    send(atrd_pkg::K_START, 8'h00);
    send(atrd_pkg::K_BYTE, 8'h41);
    send(atrd_pkg::K_START, 8'hFF);
    drain();

    // zero limit: first byte or tick times out
    write_limit(32'd0);
    send(atrd_pkg::K_START, 8'h00);
    send(atrd_pkg::K_TICK, 8'h00);
    send(atrd_pkg::K_START, 8'h00);
    send_seq(72'(OK_TERM), 6);
    drain();

    // full response: late terminator is dropped
    write_limit(32'hFFFF_FFFF);
    send(atrd_pkg::K_START, 8'h00);
    repeat (RESP_CAP + 4) begin
      b = 8'($urandom);
      if (b == 8'h0D) b = 8'h0E;
      send(atrd_pkg::K_BYTE, b);
    end
    send_seq(72'(OK_TERM), 6);
    send(atrd_pkg::K_TICK, 8'h00);
    drain();

    // limit lowered mid-wait: timeout beats the matching byte
    send(atrd_pkg::K_START, 8'h00);
    send(atrd_pkg::K_TICK, 8'h00);
    send(atrd_pkg::K_TICK, 8'h00);
    send_seq(72'(OK_TERM[47:8]), 5);
    drain();
    write_limit(32'd2);
    send(atrd_pkg::K_BYTE, 8'h0A);
    drain();

    while (n_sent < RANDOM_ITEMS) begin
      if (n_sent > RANDOM_ITEMS * 4 / 5) gaps_on = 1'b0;
      case ($urandom_range(0, 5))
        0: lim = 32'd0;
        1: lim = 32'hFFFF_FFFF;
        2: lim = 32'd1000;
        3: lim = $urandom_range(1, 8);
        4: lim = $urandom;
        default: lim = $urandom_range(2, 30);
      endcase
      write_limit(lim);
      repeat ($urandom_range(6, 16)) random_response(lim);
      drain();
    end

    if (sb.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

FILE: files.f
design/atrd_pkg.sv
design/atrd_front.sv
design/atrd_fifo.sv
design/atrd_back.sv
design/at_response_terminator_detector.sv
sim/at_response_terminator_detector_tb.sv
